// ===== sv/wasm_module_stream_parser_assert.svh =====
// Assertion macros for the module stream parser.
// Used by wasm_module_stream_parser; expects clk and rst_n in scope.
`ifndef WASM_MODULE_STREAM_PARSER_ASSERT_SVH
`define WASM_MODULE_STREAM_PARSER_ASSERT_SVH
`ifndef SYNTH
`define WMSP_ASSERT(label, prop, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);
`define WMSP_ASSERT_RST(label, prop, msg) \
  label: assert property (@(posedge clk) prop) else $error(msg);
`else
`define WMSP_ASSERT(label, prop, msg)
`define WMSP_ASSERT_RST(label, prop, msg)
`endif
`endif

// ===== sv/wmsp_pkg.sv =====
// Shared types and constants of the module stream parser.
// No dependencies.
package wmsp_pkg;

  localparam int LENGTH_BITS_DEF = 32;
  localparam logic [31:0] HDR_MAGIC = 32'h6D73_6100;
  localparam logic [7:0]  FUNC_FORM  = 8'h60;
  localparam int OUT_DEPTH = 4;

  typedef enum logic [3:0] {
    EV_HDR_OK    = 4'd0,
    EV_BAD_HDR   = 4'd1,
    EV_SEC_START = 4'd2,
    EV_TRUNC     = 4'd3,
    EV_PARAM     = 4'd4,
    EV_RESULT    = 4'd5,
    EV_FUNCTYPE  = 4'd6,
    EV_NAMEBYTE  = 4'd7,
    EV_EXPORT    = 4'd8,
    EV_BODY      = 4'd9,
    EV_LOCALS    = 4'd10,
    EV_CODEBYTE  = 4'd11,
    EV_END       = 4'd12
  } event_t;

  localparam logic [7:0] SID_TYPES   = 8'd1;
  localparam logic [7:0] SID_FUNCS   = 8'd3;
  localparam logic [7:0] SID_EXPORTS = 8'd7;
  localparam logic [7:0] SID_BODIES  = 8'd10;

  typedef struct packed {
    logic [3:0]  event_res;
    logic [7:0]  section_id;
    logic [31:0] entry_index;
    logic [7:0]  kind;
    logic [63:0] value;
    logic        last;
  } result_t;

endpackage

// ===== sv/wmsp_ifs.sv =====
// Channel interfaces of the module stream parser: byte input, result output
// and configuration write. Depends on nothing.
interface wmsp_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] data_byte;
  modport source (output valid, output data_byte, input ready);
  modport sink   (input valid, input data_byte, output ready);
endinterface

interface wmsp_out_if;
  logic        valid;
  logic        ready;
  logic [3:0]  event_res;
  logic [7:0]  section_id;
  logic [31:0] entry_index;
  logic [7:0]  kind;
  logic [63:0] value;
  logic        last;
  modport source (output valid, output event_res, output section_id, output entry_index,
                  output kind, output value, output last, input ready);
  modport sink   (input valid, input event_res, input section_id, input entry_index,
                  input kind, input value, input last, output ready);
endinterface

interface wmsp_cfg_if;
  logic        valid;
  logic        ready;
  logic [31:0] module_length;
  modport source (output valid, output module_length, input ready);
  modport sink   (input valid, input module_length, output ready);
endinterface

// ===== sv/wasm_module_stream_parser.sv =====
// Streaming WebAssembly module section parser, top level.
// Depends on wmsp_pkg, wmsp_ifs and wasm_module_stream_parser_assert.svh.
//
// Feed the module one byte per item after writing its length on cfg_wr;
// the write restarts the parse. Each byte is parsed in the cycle it is
// accepted, so one byte per cycle goes in; a byte gives zero, one or two
// result items (the end event can follow another), which drain through a
// four-entry output queue at one item per cycle while out_stream.ready is
// high. in_stream.ready drops while fewer than two queue entries are free.
`include "wasm_module_stream_parser_assert.svh"

module wasm_module_stream_parser #(
  parameter int LENGTH_BITS = wmsp_pkg::LENGTH_BITS_DEF
) (
  input  logic clk,
  input  logic rst_n,
  wmsp_in_if.sink    in_stream,
  wmsp_out_if.source out_stream,
  wmsp_cfg_if.sink   cfg_wr
);

  localparam int LB = LENGTH_BITS;
  localparam int QD = wmsp_pkg::OUT_DEPTH;
  localparam int QA = $clog2(QD);

  typedef enum logic [23:0] {
    P_HDR     = 24'h000001, P_DONE   = 24'h000002, P_SECID  = 24'h000004,
    P_SECSIZE = 24'h000008, P_SKIP   = 24'h000010, P_TCOUNT = 24'h000020,
    P_TFORM   = 24'h000040, P_TNPAR  = 24'h000080, P_TPAR   = 24'h000100,
    P_TNRES   = 24'h000200, P_TRES   = 24'h000400, P_FCOUNT = 24'h000800,
    P_FIDX    = 24'h001000, P_ECOUNT = 24'h002000, P_ELEN   = 24'h004000,
    P_ENAME   = 24'h008000, P_EKIND  = 24'h010000, P_EIDX   = 24'h020000,
    P_CCOUNT  = 24'h040000, P_CSIZE  = 24'h080000, P_LCOUNT = 24'h100000,
    P_LN      = 24'h200000, P_LTYPE  = 24'h400000, P_CBYTE  = 24'h800000
  } phase_t;

  phase_t      phase_r, phase_nxt;
  logic [LB-1:0] mlen_r, boff_r, boff_nxt, sec_end_r, sec_end_nxt, bend_r, bend_nxt;
  logic [63:0] hdr_r, hdr_nxt, acc_r, acc_nxt, ent_r, ent_nxt, items_r, items_nxt;
  logic [63:0] lrun_r, lrun_nxt;
  logic [6:0]  shift_r, shift_nxt;
  logic [7:0]  cur_sec_r, cur_sec_nxt, ekind_r, ekind_nxt;
  logic [31:0] tcnt_r, tcnt_nxt, bcnt_r, bcnt_nxt, fcnt_r, fcnt_nxt, xcnt_r, xcnt_nxt;

  wmsp_pkg::result_t q_mem [QD];
  logic [QA-1:0] head_r, tail_r;
  logic [QA:0]   cnt_r;

  logic in_acc, out_acc, cfg_acc, work;
  logic [7:0]  b;
  logic [LB-1:0] pos, leb_lim;
  logic [63:0] acc_or, v;
  logic        leb_done;
  logic        ss_do, ee_do;
  logic [63:0] ss_size;
  logic [7:0]  ss_sec;
  phase_t      ee_start;
  wmsp_pkg::result_t e0, e1;
  logic        e0_v, e1_v;
  logic [1:0]  push_n;

  assign cfg_wr.ready    = 1'b1;
  assign cfg_acc         = cfg_wr.valid && cfg_wr.ready;
  assign in_stream.ready = (cnt_r <= (QA+1)'(QD - 2));
  assign in_acc          = in_stream.valid && in_stream.ready;
  assign out_acc         = out_stream.valid && out_stream.ready;
  assign b               = in_stream.data_byte;
  assign pos             = boff_r + LB'(1);
  assign work            = in_acc && (phase_r != P_DONE) && (boff_r < mlen_r);
  assign acc_or          = acc_r | (64'(b[6:0]) << shift_r);
  assign v               = acc_or;

  always_comb begin
    leb_lim = sec_end_r;
    if (phase_r == P_SECSIZE) begin
      leb_lim = mlen_r;
    end else if (phase_r == P_LCOUNT || phase_r == P_LN) begin
      leb_lim = bend_r;
    end
  end
  assign leb_done = !b[7] || (shift_r == 7'd63) || (pos >= leb_lim);

  function automatic wmsp_pkg::result_t mk_ev(wmsp_pkg::event_t ev, logic [7:0] sec,
                                               logic [31:0] idx, logic [7:0] kd,
                                               logic [63:0] val);
    wmsp_pkg::result_t r;
    r.event_res   = ev;
    r.section_id  = sec;
    r.entry_index = idx;
    r.kind        = kd;
    r.value       = val;
    r.last        = 1'b0;
    return r;
  endfunction

  always_comb begin
    phase_nxt = phase_r;     boff_nxt = boff_r;       sec_end_nxt = sec_end_r;
    bend_nxt = bend_r;       hdr_nxt = hdr_r;         acc_nxt = acc_r;
    ent_nxt = ent_r;         items_nxt = items_r;     lrun_nxt = lrun_r;
    shift_nxt = shift_r;     cur_sec_nxt = cur_sec_r; ekind_nxt = ekind_r;
    tcnt_nxt = tcnt_r;       bcnt_nxt = bcnt_r;       fcnt_nxt = fcnt_r;
    xcnt_nxt = xcnt_r;
    e0 = '0; e1 = '0; e0_v = 1'b0; e1_v = 1'b0;
    ss_do = 1'b0; ss_size = '0; ss_sec = cur_sec_r;
    ee_do = 1'b0; ee_start = P_SKIP;
    if (work) begin
      boff_nxt = pos;
      if (phase_r == P_SECSIZE || phase_r == P_TCOUNT || phase_r == P_FCOUNT ||
          phase_r == P_ECOUNT || phase_r == P_CCOUNT || phase_r == P_TNPAR ||
          phase_r == P_TNRES || phase_r == P_FIDX || phase_r == P_ELEN ||
          phase_r == P_EIDX || phase_r == P_CSIZE || phase_r == P_LCOUNT ||
          phase_r == P_LN) begin
        if (leb_done) begin
          acc_nxt   = '0;
          shift_nxt = '0;
        end else begin
          acc_nxt   = acc_or;
          shift_nxt = shift_r + 7'd7;
        end
      end
      unique case (phase_r)
        P_HDR: begin
          if (boff_r == '0 && mlen_r < LB'(8)) begin
            e0 = mk_ev(wmsp_pkg::EV_BAD_HDR, '0, '0, '0, '0); e0_v = 1'b1;
            phase_nxt = P_DONE;
          end else begin
            hdr_nxt = hdr_r | (64'(b) << {boff_r[2:0], 3'b000});
            if (boff_r == LB'(3) && hdr_nxt[31:0] != wmsp_pkg::HDR_MAGIC) begin
              e0 = mk_ev(wmsp_pkg::EV_BAD_HDR, '0, '0, '0, 64'(hdr_nxt[31:0]));
              e0_v = 1'b1;
              phase_nxt = P_DONE;
            end else if (boff_r == LB'(7)) begin
              e0 = mk_ev(wmsp_pkg::EV_HDR_OK, '0, '0, '0, 64'(hdr_nxt[63:32]));
              e0_v = 1'b1;
              phase_nxt = P_SECID;
            end
          end
        end
        P_SECID: begin
          cur_sec_nxt = b;
          phase_nxt = P_SECSIZE;
          if (pos >= mlen_r) begin
            ss_do = 1'b1; ss_size = '0; ss_sec = b;
          end
        end
        P_SECSIZE: if (leb_done) begin
          ss_do = 1'b1; ss_size = v;
        end
        P_SKIP: ;
        P_TCOUNT, P_FCOUNT, P_ECOUNT, P_CCOUNT: if (leb_done) begin
          ent_nxt = v; ee_do = 1'b1;
          ee_start = (phase_r == P_TCOUNT) ? P_TFORM : (phase_r == P_FCOUNT) ? P_FIDX :
                     (phase_r == P_ECOUNT) ? P_ELEN : P_CSIZE;
        end
        P_TFORM: begin
          if (b == wmsp_pkg::FUNC_FORM) begin
            e0 = mk_ev(wmsp_pkg::EV_FUNCTYPE, cur_sec_r, tcnt_r, '0, 64'(b)); e0_v = 1'b1;
            tcnt_nxt = tcnt_r + 32'd1;
            phase_nxt = P_TNPAR;
          end else begin
            ee_do = 1'b1; ee_start = P_TFORM;
          end
        end
        P_TNPAR: if (leb_done) begin
          items_nxt = v;
          phase_nxt = (v != '0) ? P_TPAR : P_TNRES;
        end
        P_TPAR: begin
          e0 = mk_ev(wmsp_pkg::EV_PARAM, cur_sec_r, tcnt_r - 32'd1, '0, 64'(b)); e0_v = 1'b1;
          items_nxt = items_r - 64'd1;
          if (items_nxt == '0) phase_nxt = P_TNRES;
        end
        P_TNRES: if (leb_done) begin
          items_nxt = v;
          if (v != '0) begin
            phase_nxt = P_TRES;
          end else begin
            ee_do = 1'b1; ee_start = P_TFORM;
          end
        end
        P_TRES: begin
          e0 = mk_ev(wmsp_pkg::EV_RESULT, cur_sec_r, tcnt_r - 32'd1, '0, 64'(b)); e0_v = 1'b1;
          items_nxt = items_r - 64'd1;
          if (items_nxt == '0) begin
            ee_do = 1'b1; ee_start = P_TFORM;
          end
        end
        P_FIDX: if (leb_done) begin
          e0 = mk_ev(wmsp_pkg::EV_FUNCTYPE, cur_sec_r, fcnt_r, '0, 64'(v[31:0])); e0_v = 1'b1;
          fcnt_nxt = fcnt_r + 32'd1;
          ee_do = 1'b1; ee_start = P_FIDX;
        end
        P_ELEN: if (leb_done) begin
          if (v > 64'(sec_end_r - pos)) begin
            phase_nxt = P_EKIND;
          end else begin
            items_nxt = v;
            phase_nxt = (v != '0) ? P_ENAME : P_EKIND;
          end
        end
        P_ENAME: begin
          e0 = mk_ev(wmsp_pkg::EV_NAMEBYTE, cur_sec_r, xcnt_r, '0, 64'(b)); e0_v = 1'b1;
          items_nxt = items_r - 64'd1;
          if (items_nxt == '0) phase_nxt = P_EKIND;
        end
        P_EKIND: begin
          ekind_nxt = b;
          if (pos >= sec_end_r) begin
            e0 = mk_ev(wmsp_pkg::EV_EXPORT, cur_sec_r, xcnt_r, b, '0); e0_v = 1'b1;
            xcnt_nxt = xcnt_r + 32'd1;
            ee_do = 1'b1; ee_start = P_ELEN;
          end else begin
            phase_nxt = P_EIDX;
          end
        end
        P_EIDX: if (leb_done) begin
          e0 = mk_ev(wmsp_pkg::EV_EXPORT, cur_sec_r, xcnt_r, ekind_r, 64'(v[31:0]));
          e0_v = 1'b1;
          xcnt_nxt = xcnt_r + 32'd1;
          ee_do = 1'b1; ee_start = P_ELEN;
        end
        P_CSIZE: if (leb_done) begin
          if (v > 64'(sec_end_r - pos)) begin
            e0 = mk_ev(wmsp_pkg::EV_TRUNC, cur_sec_r, '0, '0, v); e0_v = 1'b1;
            phase_nxt = P_SKIP;
          end else begin
            bend_nxt = LB'(64'(pos) + v);
            e0 = mk_ev(wmsp_pkg::EV_BODY, cur_sec_r, bcnt_r, '0, v); e0_v = 1'b1;
            bcnt_nxt = bcnt_r + 32'd1;
            phase_nxt = P_LCOUNT;
          end
        end
        P_LCOUNT: if (leb_done) begin
          items_nxt = v;
          phase_nxt = (v != '0) ? P_LN : P_CBYTE;
        end
        P_LN: if (leb_done) begin
          lrun_nxt = v;
          phase_nxt = P_LTYPE;
        end
        P_LTYPE: begin
          e0 = mk_ev(wmsp_pkg::EV_LOCALS, cur_sec_r, bcnt_r - 32'd1, b, lrun_r); e0_v = 1'b1;
          lrun_nxt = '0;
          items_nxt = items_r - 64'd1;
          phase_nxt = (items_nxt == '0) ? P_CBYTE : P_LN;
        end
        P_CBYTE: begin
          e0 = mk_ev(wmsp_pkg::EV_CODEBYTE, cur_sec_r, bcnt_r - 32'd1, '0, 64'(b));
          e0_v = 1'b1;
        end
        default: phase_nxt = P_DONE;
      endcase

      if (ss_do) begin
        if (ss_size > 64'(mlen_r - pos)) begin
          e0 = mk_ev(wmsp_pkg::EV_TRUNC, ss_sec, '0, '0, ss_size); e0_v = 1'b1;
          phase_nxt = P_DONE;
        end else begin
          sec_end_nxt = LB'(64'(pos) + ss_size);
          e0 = mk_ev(wmsp_pkg::EV_SEC_START, ss_sec, '0, '0, ss_size); e0_v = 1'b1;
          case (ss_sec)
            wmsp_pkg::SID_TYPES:   phase_nxt = P_TCOUNT;
            wmsp_pkg::SID_FUNCS:   phase_nxt = P_FCOUNT;
            wmsp_pkg::SID_EXPORTS: phase_nxt = P_ECOUNT;
            wmsp_pkg::SID_BODIES:  phase_nxt = P_CCOUNT;
            default:               phase_nxt = P_SKIP;
          endcase
        end
      end
      if (ee_do) begin
        if (ent_nxt == '0) begin
          phase_nxt = P_SKIP;
        end else begin
          ent_nxt = ent_nxt - 64'd1;
          phase_nxt = ee_start;
        end
      end

      // body end, then section end, then module end
      if ((phase_nxt == P_LCOUNT || phase_nxt == P_LN || phase_nxt == P_LTYPE ||
           phase_nxt == P_CBYTE) && pos >= bend_nxt) begin
        if (ent_nxt == '0) begin
          phase_nxt = P_SKIP;
        end else begin
          ent_nxt = ent_nxt - 64'd1;
          phase_nxt = P_CSIZE;
        end
      end
      if (phase_nxt != P_HDR && phase_nxt != P_DONE && phase_nxt != P_SECID &&
          phase_nxt != P_SECSIZE && pos >= sec_end_nxt) begin
        phase_nxt = P_SECID;
      end
      if (phase_nxt == P_SECID && pos >= mlen_r) begin
        e1 = mk_ev(wmsp_pkg::EV_END, '0, '0, '0, 64'(mlen_r)); e1_v = 1'b1;
        phase_nxt = P_DONE;
      end
    end
  end

  always_comb begin
    push_n = {1'b0, e0_v} + {1'b0, e1_v};
  end

  always_ff @(posedge clk) begin
    if (!rst_n || cfg_acc) begin
      phase_r <= P_HDR;
      boff_r <= '0; sec_end_r <= '0; bend_r <= '0; hdr_r <= '0; acc_r <= '0;
      ent_r <= '0; items_r <= '0; lrun_r <= '0; shift_r <= '0; cur_sec_r <= '0;
      ekind_r <= '0; tcnt_r <= '0; bcnt_r <= '0; fcnt_r <= '0; xcnt_r <= '0;
    end else begin
      phase_r <= phase_nxt;
      boff_r <= boff_nxt; sec_end_r <= sec_end_nxt; bend_r <= bend_nxt;
      hdr_r <= hdr_nxt; acc_r <= acc_nxt; ent_r <= ent_nxt; items_r <= items_nxt;
      lrun_r <= lrun_nxt; shift_r <= shift_nxt; cur_sec_r <= cur_sec_nxt;
      ekind_r <= ekind_nxt; tcnt_r <= tcnt_nxt; bcnt_r <= bcnt_nxt;
      fcnt_r <= fcnt_nxt; xcnt_r <= xcnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mlen_r <= '0;
    end else if (cfg_acc) begin
      mlen_r <= LB'(cfg_wr.module_length);
    end
  end

  // result queue
  always_ff @(posedge clk) begin
    if (e0_v) begin
      q_mem[tail_r] <= '{event_res: e0.event_res, section_id: e0.section_id,
                         entry_index: e0.entry_index, kind: e0.kind, value: e0.value,
                         last: !e1_v};
      if (e1_v) begin
        q_mem[tail_r + QA'(1)] <= '{event_res: e1.event_res, section_id: e1.section_id,
                                   entry_index: e1.entry_index, kind: e1.kind,
                                   value: e1.value, last: 1'b1};
      end
    end else if (e1_v) begin
      q_mem[tail_r] <= '{event_res: e1.event_res, section_id: e1.section_id,
                         entry_index: e1.entry_index, kind: e1.kind, value: e1.value,
                         last: 1'b1};
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      head_r <= '0;
      tail_r <= '0;
      cnt_r  <= '0;
    end else begin
      tail_r <= tail_r + QA'(push_n);
      head_r <= head_r + QA'(out_acc);
      cnt_r  <= cnt_r + (QA+1)'(push_n) - (QA+1)'(out_acc);
    end
  end

  assign out_stream.valid       = (cnt_r != '0);
  assign out_stream.event_res   = q_mem[head_r].event_res;
  assign out_stream.section_id  = q_mem[head_r].section_id;
  assign out_stream.entry_index = q_mem[head_r].entry_index;
  assign out_stream.kind        = q_mem[head_r].kind;
  assign out_stream.value       = q_mem[head_r].value;
  assign out_stream.last        = q_mem[head_r].last;

  `WMSP_ASSERT_RST(a_rst_empty, !rst_n |=> cnt_r == '0, "result queue not empty after reset")
  `WMSP_ASSERT(a_q_bound, cnt_r <= (QA+1)'(QD), "result queue overflow")
  `WMSP_ASSERT(a_done_quiet, in_acc && phase_r == P_DONE |-> push_n == 2'd0,
               "result after parse end")
  `WMSP_ASSERT(a_cfg_restart, cfg_acc |=> boff_r == '0 && phase_r == P_HDR,
               "configuration write did not restart parse")
  `WMSP_ASSERT(a_off_bound, boff_r <= mlen_r, "byte offset past module length")

endmodule

// ===== tb/tb.sv =====
// Self-checking testbench for wasm_module_stream_parser: feeds module bytes,
// predicts the parser events in SystemVerilog and checks every result item.
// Depends on wmsp_pkg, wmsp_ifs and the parser RTL.
module tb;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int WATCHDOG_LIMIT = 2000;
  localparam int STALL_CYCLES = 60;
  localparam int SETTLE_CYCLES = 8;

  typedef enum logic [4:0] {
    PH_HDR, PH_DONE, PH_SECID, PH_SECSIZE, PH_SKIP,
    PH_TCOUNT, PH_TFORM, PH_TNPAR, PH_TPAR, PH_TNRES, PH_TRES,
    PH_FCOUNT, PH_FIDX,
    PH_ECOUNT, PH_ELEN, PH_ENAME, PH_EKIND, PH_EIDX,
    PH_CCOUNT, PH_CSIZE, PH_LCOUNT, PH_LN, PH_LTYPE, PH_CBYTE
  } parse_phase_e;

  logic clk = 1'b0;
  logic rst_n;
  logic quiet;
  logic stall_req;
  int   stall_left;
  int   idle_cycles;
  int   fails;

  wmsp_in_if  in_if();
  wmsp_out_if out_if();
  wmsp_cfg_if cfg_if();

  wasm_module_stream_parser dut (
    .clk(clk),
    .rst_n(rst_n),
    .in_stream(in_if),
    .out_stream(out_if),
    .cfg_wr(cfg_if)
  );

  always begin
    #6 clk = 1'b1;
    #6 clk = 1'b0;
  end

  // parser shadow state
  logic [31:0]  mod_len;
  parse_phase_e ph;
  logic [63:0]  offs, hdr_bits, sec_end, body_lim, leb_acc;
  logic [63:0]  entries_left, items_left, local_run;
  logic [7:0]   cur_sec, exp_kind;
  int unsigned  leb_shift;
  logic [31:0]  type_cnt, body_cnt, func_cnt, export_cnt;
  wmsp_pkg::result_t byte_events[$];
  wmsp_pkg::result_t expected_events[$];
  wmsp_pkg::result_t got_event;

  logic [7:0] mod_q[$], sec_q[$], body_q[$];

  function void parser_restart(input logic [31:0] len);
    mod_len = len;
    ph = PH_HDR;
    offs = 0; hdr_bits = 0; sec_end = 0; body_lim = 0; leb_acc = 0;
    entries_left = 0; items_left = 0; local_run = 0;
    cur_sec = 0; exp_kind = 0; leb_shift = 0;
    type_cnt = 0; body_cnt = 0; func_cnt = 0; export_cnt = 0;
  endfunction

  function void note_event(input wmsp_pkg::event_t ev, input logic [7:0] sec,
                           input logic [31:0] idx, input logic [7:0] k,
                           input logic [63:0] v);
    wmsp_pkg::result_t r;
    if (byte_events.size() >= 3) return;
    r.event_res = ev;
    r.section_id = sec;
    r.entry_index = idx;
    r.kind = k;
    r.value = v;
    r.last = 1'b0;
    byte_events = {byte_events, r};
  endfunction

  function bit leb_step(input logic [7:0] b, input logic [63:0] limit);
    if (leb_shift < 64) leb_acc |= {57'd0, b[6:0]} << leb_shift;
    if (!b[7]) return 1'b1;
    leb_shift += 7;
    if (leb_shift >= 64) return 1'b1;
    return offs >= limit;
  endfunction

  function logic [63:0] leb_pop();
    logic [63:0] v;
    v = leb_acc;
    leb_acc = 0;
    leb_shift = 0;
    return v;
  endfunction

  function void next_entry(input parse_phase_e start);
    if (entries_left == 0) begin
      ph = PH_SKIP;
    end else begin
      entries_left--;
      ph = start;
    end
  endfunction

  function void open_section(input logic [63:0] size);
    logic [63:0] m;
    m = {32'd0, mod_len};
    if (size > m - offs) begin
      note_event(wmsp_pkg::EV_TRUNC, cur_sec, 0, 0, size);
      ph = PH_DONE;
      return;
    end
    sec_end = offs + size;
    note_event(wmsp_pkg::EV_SEC_START, cur_sec, 0, 0, size);
    case (cur_sec)
      wmsp_pkg::SID_TYPES:   ph = PH_TCOUNT;
      wmsp_pkg::SID_FUNCS:   ph = PH_FCOUNT;
      wmsp_pkg::SID_EXPORTS: ph = PH_ECOUNT;
      wmsp_pkg::SID_BODIES:  ph = PH_CCOUNT;
      default:               ph = PH_SKIP;
    endcase
  endfunction

  function void parse_byte(input logic [7:0] b);
    logic [63:0] m, v, pos, off;
    logic [7:0]  sec;
    m = {32'd0, mod_len};
    sec = cur_sec;
    if (ph == PH_DONE || offs >= m) return;
    byte_events.delete();
    offs++;
    pos = offs;
    case (ph)
      PH_HDR: begin
        off = pos - 1;
        if (off == 0 && m < 8) begin
          note_event(wmsp_pkg::EV_BAD_HDR, 0, 0, 0, 0);
          ph = PH_DONE;
        end else begin
          hdr_bits |= {56'd0, b} << ((off & 7) * 8);
          if (off == 3 && hdr_bits[31:0] != wmsp_pkg::HDR_MAGIC) begin
            note_event(wmsp_pkg::EV_BAD_HDR, 0, 0, 0, {32'd0, hdr_bits[31:0]});
            ph = PH_DONE;
          end else if (off == 7) begin
            note_event(wmsp_pkg::EV_HDR_OK, 0, 0, 0, hdr_bits >> 32);
            ph = PH_SECID;
          end
        end
      end
      PH_SECID: begin
        cur_sec = b;
        ph = PH_SECSIZE;
        if (pos >= m) open_section(0);
      end
      PH_SECSIZE: if (leb_step(b, m)) open_section(leb_pop());
      PH_SKIP: ;
      PH_TCOUNT, PH_FCOUNT, PH_ECOUNT, PH_CCOUNT: begin
        if (leb_step(b, sec_end)) begin
          entries_left = leb_pop();
          next_entry(ph == PH_TCOUNT ? PH_TFORM : ph == PH_FCOUNT ? PH_FIDX :
                     ph == PH_ECOUNT ? PH_ELEN : PH_CSIZE);
        end
      end
      PH_TFORM: begin
        if (b == wmsp_pkg::FUNC_FORM) begin
          note_event(wmsp_pkg::EV_FUNCTYPE, sec, type_cnt, 0, {56'd0, wmsp_pkg::FUNC_FORM});
          type_cnt++;
          ph = PH_TNPAR;
        end else begin
          next_entry(PH_TFORM);
        end
      end
      PH_TNPAR: begin
        if (leb_step(b, sec_end)) begin
          items_left = leb_pop();
          ph = (items_left != 0) ? PH_TPAR : PH_TNRES;
        end
      end
      PH_TPAR: begin
        note_event(wmsp_pkg::EV_PARAM, sec, type_cnt - 32'd1, 0, {56'd0, b});
        items_left--;
        if (items_left == 0) ph = PH_TNRES;
      end
      PH_TNRES: begin
        if (leb_step(b, sec_end)) begin
          items_left = leb_pop();
          if (items_left != 0) ph = PH_TRES;
          else next_entry(PH_TFORM);
        end
      end
      PH_TRES: begin
        note_event(wmsp_pkg::EV_RESULT, sec, type_cnt - 32'd1, 0, {56'd0, b});
        items_left--;
        if (items_left == 0) next_entry(PH_TFORM);
      end
      PH_FIDX: begin
        if (leb_step(b, sec_end)) begin
          v = leb_pop();
          note_event(wmsp_pkg::EV_FUNCTYPE, sec, func_cnt, 0, {32'd0, v[31:0]});
          func_cnt++;
          next_entry(PH_FIDX);
        end
      end
      PH_ELEN: begin
        if (leb_step(b, sec_end)) begin
          v = leb_pop();
          if (v > sec_end - pos) begin
            ph = PH_EKIND;
          end else begin
            items_left = v;
            ph = (v != 0) ? PH_ENAME : PH_EKIND;
          end
        end
      end
      PH_ENAME: begin
        note_event(wmsp_pkg::EV_NAMEBYTE, sec, export_cnt, 0, {56'd0, b});
        items_left--;
        if (items_left == 0) ph = PH_EKIND;
      end
      PH_EKIND: begin
        exp_kind = b;
        if (pos >= sec_end) begin
          note_event(wmsp_pkg::EV_EXPORT, sec, export_cnt, exp_kind, 0);
          export_cnt++;
          next_entry(PH_ELEN);
        end else begin
          ph = PH_EIDX;
        end
      end
      PH_EIDX: begin
        if (leb_step(b, sec_end)) begin
          v = leb_pop();
          note_event(wmsp_pkg::EV_EXPORT, sec, export_cnt, exp_kind, {32'd0, v[31:0]});
          export_cnt++;
          next_entry(PH_ELEN);
        end
      end
      PH_CSIZE: begin
        if (leb_step(b, sec_end)) begin
          v = leb_pop();
          if (v > sec_end - pos) begin
            note_event(wmsp_pkg::EV_TRUNC, sec, 0, 0, v);
            ph = PH_SKIP;
          end else begin
            body_lim = pos + v;
            note_event(wmsp_pkg::EV_BODY, sec, body_cnt, 0, v);
            body_cnt++;
            ph = PH_LCOUNT;
          end
        end
      end
      PH_LCOUNT: begin
        if (leb_step(b, body_lim)) begin
          items_left = leb_pop();
          ph = (items_left != 0) ? PH_LN : PH_CBYTE;
        end
      end
      PH_LN: begin
        if (leb_step(b, body_lim)) begin
          local_run = leb_pop();
          ph = PH_LTYPE;
        end
      end
      PH_LTYPE: begin
        note_event(wmsp_pkg::EV_LOCALS, sec, body_cnt - 32'd1, b, local_run);
        local_run = 0;
        items_left--;
        ph = (items_left == 0) ? PH_CBYTE : PH_LN;
      end
      PH_CBYTE: note_event(wmsp_pkg::EV_CODEBYTE, sec, body_cnt - 32'd1, 0, {56'd0, b});
      default: ph = PH_DONE;
    endcase

    if (ph >= PH_LCOUNT && pos >= body_lim) next_entry(PH_CSIZE);
    if (ph >= PH_SKIP && pos >= sec_end) ph = PH_SECID;
    if (ph == PH_SECID && pos >= m) begin
      note_event(wmsp_pkg::EV_END, 0, 0, 0, m);
      ph = PH_DONE;
    end
    if (byte_events.size() > 0) byte_events[byte_events.size() - 1].last = 1'b1;
    expected_events = {expected_events, byte_events};
  endfunction

  // module image builders
  function automatic void put_leb(ref logic [7:0] q[$], input logic [63:0] v);
    logic [7:0]  b;
    logic [63:0] rest;
    rest = v;
    do begin
      b = {1'b0, rest[6:0]};
      rest = rest >> 7;
      if (rest != 0) b[7] = 1'b1;
      q = {q, b};
    end while (rest != 0);
  endfunction

  function void put_header(input logic [31:0] version);
    mod_q = {mod_q, 8'h00, 8'h61, 8'h73, 8'h6D};
    for (int i = 0; i < 4; i++) mod_q = {mod_q, version[i*8 +: 8]};
  endfunction

  function void close_section(input logic [7:0] id);
    mod_q = {mod_q, id};
    put_leb(mod_q, 64'(sec_q.size()));
    mod_q = {mod_q, sec_q};
    sec_q.delete();
  endfunction

  function void close_body();
    put_leb(sec_q, 64'(body_q.size()));
    sec_q = {sec_q, body_q};
    body_q.delete();
  endfunction

  function logic [63:0] rand_val();
    case ($urandom_range(3))
      0: return 64'($urandom_range(127));
      1: return 64'($urandom_range(16383));
      2: return 64'($urandom);
      default: return {$urandom, $urandom};
    endcase
  endfunction

  function void rand_type_section();
    int n, k;
    n = $urandom_range(3);
    put_leb(sec_q, 64'(n));
    for (int i = 0; i < n; i++) begin
      if ($urandom_range(9) == 0) begin
        sec_q = {sec_q, 8'h40};
      end else begin
        sec_q = {sec_q, wmsp_pkg::FUNC_FORM};
        for (int j = 0; j < 2; j++) begin
          k = $urandom_range(3);
          put_leb(sec_q, 64'(k));
          repeat (k) sec_q = {sec_q, 8'($urandom_range(255))};
        end
      end
    end
  endfunction

  function void rand_export_section();
    int n, k;
    n = $urandom_range(3);
    put_leb(sec_q, 64'(n));
    for (int i = 0; i < n; i++) begin
      k = $urandom_range(4);
      put_leb(sec_q, 64'(k));
      repeat (k) sec_q = {sec_q, 8'($urandom_range(255))};
      sec_q = {sec_q, 8'($urandom_range(255))};
      put_leb(sec_q, rand_val());
    end
  endfunction

  function void rand_code_section();
    int n, k;
    n = $urandom_range(2);
    put_leb(sec_q, 64'(n));
    for (int i = 0; i < n; i++) begin
      k = $urandom_range(2);
      put_leb(body_q, 64'(k));
      repeat (k) begin
        put_leb(body_q, rand_val());
        body_q = {body_q, 8'($urandom_range(255))};
      end
      repeat ($urandom_range(6)) body_q = {body_q, 8'($urandom_range(255))};
      close_body();
    end
  endfunction

  // channel drivers
  task send_item(input logic [7:0] b);
    while (!quiet && $urandom_range(99) < 22) begin
      in_if.valid <= 1'b0;
      @(posedge clk);
    end
    in_if.valid <= 1'b1;
    in_if.data_byte <= b;
    do @(posedge clk); while (!in_if.ready);
    parse_byte(b);
  endtask

  task send_module();
    foreach (mod_q[i]) send_item(mod_q[i]);
    in_if.valid <= 1'b0;
    mod_q.delete();
  endtask

  task settle();
    while (expected_events.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task write_length(input logic [31:0] len);
    settle();
    cfg_if.valid <= 1'b1;
    cfg_if.module_length <= len;
    do @(posedge clk); while (!cfg_if.ready);
    cfg_if.valid <= 1'b0;
    parser_restart(len);
  endtask

  // result side
  always @(posedge clk) begin
    if (!rst_n) begin
      out_if.ready <= 1'b0;
      stall_left <= 0;
    end else if (stall_left > 0) begin
      out_if.ready <= 1'b0;
      stall_left <= stall_left - 1;
    end else if (stall_req) begin
      out_if.ready <= 1'b0;
      stall_left <= STALL_CYCLES;
    end else begin
      out_if.ready <= quiet || ($urandom_range(99) >= 22);
    end
  end

  function void check_field(input string name, input logic [63:0] want, input logic [63:0] got);
    if (want !== got) begin
      $error("%s: expected 0x%0h, got 0x%0h", name, want, got);
      fails++;
    end
  endfunction

  always @(posedge clk) begin
    if (rst_n && out_if.valid && out_if.ready) begin
      if (expected_events.size() == 0) begin
        $error("unexpected result item: event %0d value 0x%0h", out_if.event_res, out_if.value);
        fails++;
      end else begin
        got_event = expected_events.pop_front();
        check_field("event_res", 64'(got_event.event_res), 64'(out_if.event_res));
        check_field("section_id", 64'(got_event.section_id), 64'(out_if.section_id));
        check_field("entry_index", 64'(got_event.entry_index), 64'(out_if.entry_index));
        check_field("kind", 64'(got_event.kind), 64'(out_if.kind));
        check_field("value", got_event.value, out_if.value);
        check_field("last", 64'(got_event.last), 64'(out_if.last));
      end
    end
  end

  always @(posedge clk) begin
    if ((in_if.valid && in_if.ready) || (out_if.valid && out_if.ready) ||
        (cfg_if.valid && cfg_if.ready)) begin
      idle_cycles <= 0;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
    if (idle_cycles >= WATCHDOG_LIMIT) begin
      $display("wasm_module_stream_parser regression: fail");
      $finish;
    end
  end

  // tests
  task test_empty_module();
    write_length(32'd0);
    mod_q = '{8'h00, 8'h61, 8'h73, 8'h6D};
    send_module();
  endtask

  task test_short_module();
    write_length(32'd5);
    put_header(32'd1);
    send_module();
  endtask

  task test_bad_magic();
    write_length(32'd12);
    mod_q = '{8'h00, 8'h61, 8'h73, 8'h6E, 8'h01, 8'h00, 8'h00, 8'h00, 8'hFF};
    send_module();
  endtask

  task test_header_only();
    write_length(32'd8);
    put_header(32'hFFFF_FFFF);
    mod_q = {mod_q, 8'h01, 8'h80};
    send_module();
  endtask

  task test_known_sections();
    put_header(32'd1);
    sec_q = '{8'h03, 8'h60, 8'h02, 8'h7F, 8'h7E, 8'h01, 8'h7F, 8'h40, 8'h60, 8'h00, 8'h00};
    close_section(wmsp_pkg::SID_TYPES);
    sec_q = '{8'h02, 8'h00};
    put_leb(sec_q, 64'd300);
    close_section(wmsp_pkg::SID_FUNCS);
    sec_q = '{8'hAA, 8'h55, 8'hFF};
    close_section(8'd0);
    sec_q = '{8'h01, 8'h02, 8'h61, 8'h62, 8'h00, 8'h05};
    close_section(wmsp_pkg::SID_EXPORTS);
    sec_q = '{8'h02};
    body_q = '{8'h01, 8'h02, 8'h7F, 8'h0B};
    close_body();
    body_q = '{8'h00, 8'h0B};
    close_body();
    close_section(wmsp_pkg::SID_BODIES);
    write_length(32'(mod_q.size()));
    send_module();
  endtask

  // oversized name, kind as last byte, section ending before the kind
  task test_export_edges();
    put_header(32'd1);
    sec_q = '{8'h02, 8'h32, 8'h03, 8'h01, 8'h00, 8'h02};
    close_section(wmsp_pkg::SID_EXPORTS);
    sec_q = '{8'h01, 8'h01, 8'h78};
    close_section(wmsp_pkg::SID_EXPORTS);
    write_length(32'(mod_q.size()));
    send_module();
  endtask

  // locals cut short, size cut at section end, body too long, section too long
  task test_code_edges();
    put_header(32'd1);
    sec_q = '{8'h02, 8'h01, 8'h01, 8'h85};
    close_section(wmsp_pkg::SID_BODIES);
    sec_q = '{8'h01, 8'h28, 8'h00, 8'h00};
    close_section(wmsp_pkg::SID_BODIES);
    mod_q = {mod_q, 8'h00, 8'h7F};
    repeat (5) mod_q = {mod_q, 8'($urandom_range(255))};
    write_length(32'(mod_q.size()));
    send_module();
  endtask

  task test_wide_fields();
    put_header(32'h8000_0001);
    sec_q = '{8'h01};
    repeat (9) sec_q = {sec_q, 8'hFF};
    sec_q = {sec_q, 8'h01};
    close_section(wmsp_pkg::SID_FUNCS);
    write_length(32'hFFFF_FFFF);
    send_module();
  endtask

  task test_backpressure();
    put_header(32'd1);
    sec_q = '{8'h01};
    body_q = '{8'h00};
    repeat (12) body_q = {body_q, 8'($urandom_range(255))};
    close_body();
    close_section(wmsp_pkg::SID_BODIES);
    write_length(32'(mod_q.size()));
    quiet <= 1'b1;
    stall_req <= 1'b1;
    @(posedge clk);
    stall_req <= 1'b0;
    send_module();
    quiet <= 1'b0;
  endtask

  task test_random_modules();
    int sent, n, sz, len;
    sent = 0;
    n = 0;
    while (sent < 16) begin
      put_header($urandom);
      if ($urandom_range(11) == 0) mod_q[$urandom_range(3)] ^= 8'h01 << $urandom_range(7);
      repeat ($urandom_range(1, 4)) begin
        case ($urandom_range(4))
          0: begin rand_type_section(); close_section(wmsp_pkg::SID_TYPES); end
          1: begin
            put_leb(sec_q, 64'd2);
            put_leb(sec_q, rand_val());
            put_leb(sec_q, rand_val());
            close_section(wmsp_pkg::SID_FUNCS);
          end
          2: begin rand_export_section(); close_section(wmsp_pkg::SID_EXPORTS); end
          3: begin rand_code_section(); close_section(wmsp_pkg::SID_BODIES); end
          default: begin
            repeat ($urandom_range(5)) sec_q = {sec_q, 8'($urandom_range(255))};
            close_section(8'($urandom_range(255)));
          end
        endcase
      end
      sz = mod_q.size();
      if ($urandom_range(7) == 0) mod_q[$urandom_range(8, sz - 1)] = 8'($urandom_range(255));
      len = sz;
      case ($urandom_range(19)) inside
        [14:16]: len = $urandom_range(sz - 1);
        [17:19]: repeat ($urandom_range(1, 4)) mod_q = {mod_q, 8'($urandom_range(255))};
        default: ;
      endcase
      quiet <= (n % 4 == 0);
      write_length(32'(len));
      sent += mod_q.size();
      send_module();
      n++;
    end
    quiet <= 1'b0;
  endtask

  initial begin
    rst_n = 1'b0;
    quiet = 1'b0;
    stall_req = 1'b0;
    idle_cycles = 0;
    fails = 0;
    in_if.valid = 1'b0;
    in_if.data_byte = 8'd0;
    cfg_if.valid = 1'b0;
    cfg_if.module_length = 32'd0;
    out_if.ready = 1'b0;
    parser_restart(32'd0);
    repeat (5) @(posedge clk);
    rst_n <= 1'b1;
    test_empty_module();
    test_short_module();
    test_bad_magic();
    test_header_only();
    test_known_sections();
    test_export_edges();
    test_code_edges();
    test_wide_fields();
    test_backpressure();
    test_random_modules();
    settle();
    if (fails == 0) begin
      $display("wasm_module_stream_parser regression: pass");
    end else begin
      $display("wasm_module_stream_parser regression: fail");
    end
    $finish;
  end
endmodule

// ===== wasm_module_stream_parser.f =====
+incdir+sv
sv/wmsp_pkg.sv
sv/wmsp_ifs.sv
sv/wasm_module_stream_parser.sv
tb/tb.sv
